// ===== hdl/scope_trace_render_top_macros.svh =====
// Assertion macros used by the scope trace renderer checker.
`ifndef SCOPE_TRACE_RENDER_TOP_MACROS_SVH
`define SCOPE_TRACE_RENDER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scope trace render check failed");

// Consequent must hold in the cycle after the antecedent.
`define STR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scope trace render check failed");

`endif

// ===== hdl/str_pkg.sv =====
// Shared types, constants and helper functions of the scope trace renderer.
package str_pkg;

	// frame geometry
	localparam int FRAME_WIDTH  = 256;
	localparam int FRAME_HEIGHT = 256;
	localparam int ADDR_W       = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
	localparam int ROW_W        = $clog2(FRAME_HEIGHT);
	localparam int PIX_W        = 24;

	// rectangle arithmetic: 11-bit registers widened by one bit
	localparam int REG_W   = 11;
	localparam int COORD_W = 12;
	localparam int W_W     = 11;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_CNT  = 3'd7;

	// commands
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_PLOT  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// shared divider: 28-bit dividend, 16-bit divisor, two bits a cycle
	localparam int DIV_NW    = 28;
	localparam int DIV_DW    = 16;
	localparam int DIV_STEPS = DIV_NW / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// gain numerator scale: 1/(1.1 - x) in Q4.12 is 40960/(11 - 10x)
	localparam int GAIN_NUM = 40960;

	typedef struct packed {
		logic [1:0]         command;
		logic [7:0]         pixel_x;
		logic [7:0]         pixel_y;
		logic [PIX_W-1:0]   pixel_data;
		logic signed [15:0] sample;
		logic               first_sample;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0] read_data;
		logic             plotted;
		logic [7:0]       plot_x;
		logic [7:0]       plot_y;
		logic [PIX_W-1:0] new_pixel;
	} rsp_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quot;
	} div_rsp_t;

	// linear frame address of a pixel
	function automatic logic [ADDR_W-1:0] addr_of(input int x, input int y);
		return ADDR_W'(y * FRAME_WIDTH + x);
	endfunction

	// scale one colour channel by a Q4.12 gain and cap at full scale; plain passes it unchanged
	function automatic logic [7:0] shade_ch(input logic [7:0] col, input logic [15:0] gain,
			input logic plain);
		logic [23:0] prod;
		logic [11:0] v;
		prod = 24'(col) * 24'(gain);
		v = prod[23:12];
		if (plain)
			return col;
		return (v > 12'd255) ? 8'd255 : v[7:0];
	endfunction

	// add two channels with saturation
	function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? 8'd255 : s[7:0];
	endfunction

endpackage

// ===== hdl/str_div.sv =====
// Shared iterative unsigned divider, restoring, two quotient bits a cycle.
module str_div (
	input  logic              clk,
	input  logic              arst_n,
	input  str_pkg::div_req_t dreq,
	output str_pkg::div_rsp_t drsp
);

	logic [str_pkg::DIV_DW-1:0]    rem_q;
	logic [str_pkg::DIV_NW-1:0]    quo_q;
	logic [str_pkg::DIV_DW-1:0]    den_q;
	logic [str_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          run_q;
	logic                          done_q;
	logic [str_pkg::DIV_DW-1:0]    rem_d;
	logic [str_pkg::DIV_NW-1:0]    quo_d;

	// two compare-subtract steps; dividend bits shift out as quotient bits shift in
	always_comb begin
		logic [str_pkg::DIV_DW:0] t;
		rem_d = rem_q;
		quo_d = quo_q;
		for (int i = 0; i < 2; i++) begin
			t = {rem_d, quo_d[str_pkg::DIV_NW-1]};
			quo_d = {quo_d[str_pkg::DIV_NW-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				t = t - {1'b0, den_q};
				quo_d[0] = 1'b1;
			end
			rem_d = t[str_pkg::DIV_DW-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (dreq.start) begin
				cnt_q <= str_pkg::DIV_CNT_W'(str_pkg::DIV_STEPS);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == str_pkg::DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (dreq.start) begin
			rem_q <= '0;
			quo_q <= dreq.num;
			den_q <= dreq.den;
		end else if (run_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign drsp.done = done_q;
	assign drsp.quot = quo_q;

endmodule

// ===== hdl/str_fb_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module str_fb_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 24
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== hdl/scope_trace_render_top.sv =====
// Top level of the scope trace renderer: control sequencer, registers and frame store.
//
// Request channel (req_valid, req_stall, req) carries one command: pixel write, pixel
// read, plot sample or none. Response channel (rsp_valid, rsp_stall, rsp) returns exactly one
// response per request, in order. The user must write the registers through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block does not enforce this.
// One request is handled at a time; req_stall is high from acceptance until the
// response is loaded into the output register. A pixel write goes straight to S_DONE and a
// pixel read passes S_RD_WAIT; a plot passes S_PREP and S_COL, waits in S_COL_WAIT on
// the shared divider for the column and, unless the rectangle is a single row, in
// S_GAIN_WAIT for the row gain, then does the read-modify-write of the frame store
// through S_SHADE and S_SUM. A plot outside the rectangle ends after S_COL or S_COL_WAIT.
// The frame store has no reset; a pixel must be written before it is read or drawn on.
// Reset clears the sample index, loads the register defaults and empties the output.
// A stalled response holds in the output register; the next request is still taken, and
// its response waits in S_DONE until it can be moved there.
module scope_trace_render_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  str_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output str_pkg::rsp_t                  rsp,
	input  logic                           cfg_we,
	input  logic [str_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [str_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_COL, S_COL_WAIT, S_GAIN_WAIT, S_SHADE, S_SUM, S_RD_WAIT, S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [str_pkg::REG_W-1:0] left_cfg_q, top_cfg_q, right_cfg_q, bottom_cfg_q;
	logic [7:0]                red_q, green_q, blue_q;
	logic [15:0]               count_q;

	// plot context
	logic [15:0]                       sidx_q;
	logic [15:0]                       idx_q;
	logic [15:0]                       sample_q;
	logic signed [str_pkg::COORD_W-1:0] left_q, top_q, w_q, fx_q, fy_q;
	logic                              hok_q;
	logic [str_pkg::ROW_W-1:0]         c2_q, row_q;
	logic [str_pkg::ADDR_W-1:0]        addr_q;
	logic [15:0]                       gain_q;
	logic                              plain_q;
	logic [str_pkg::PIX_W-1:0]         shade_q;
	str_pkg::rsp_t                     res_q, rsp_q;
	logic                              rsp_valid_q;

	// frame store and divider hookup
	logic                        ram_we, ram_re;
	logic [str_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [str_pkg::PIX_W-1:0]   ram_wdata, ram_rdata;
	str_pkg::div_req_t           dreq;
	str_pkg::div_rsp_t           drsp;

	// combinational helpers
	logic                              accept, in_frame;
	logic signed [str_pkg::COORD_W-1:0] lft_c, tp_c, rgt_c, bot_c, w_c, h_c;
	logic signed [str_pkg::COORD_W-1:0] fx_c, fy_c;
	logic [str_pkg::ADDR_W-1:0]        addr_c;
	logic [str_pkg::ROW_W:0]           two_row, row_dev;
	logic                              col_out;
	logic [7:0]                        new_r, new_g, new_b;

	assign accept   = req_valid && !req_stall;
	assign in_frame = (int'(req.pixel_x) < str_pkg::FRAME_WIDTH) &&
	                  (int'(req.pixel_y) < str_pkg::FRAME_HEIGHT);

	// rectangle clipped to the frame
	always_comb begin
		lft_c = left_cfg_q[str_pkg::REG_W-1] ? '0 : {1'b0, left_cfg_q};
		tp_c  = top_cfg_q[str_pkg::REG_W-1] ? '0 : {1'b0, top_cfg_q};
		rgt_c = {right_cfg_q[str_pkg::REG_W-1], right_cfg_q};
		bot_c = {bottom_cfg_q[str_pkg::REG_W-1], bottom_cfg_q};
		if (rgt_c > str_pkg::COORD_W'(str_pkg::FRAME_WIDTH - 1))
			rgt_c = str_pkg::COORD_W'(str_pkg::FRAME_WIDTH - 1);
		if (bot_c > str_pkg::COORD_W'(str_pkg::FRAME_HEIGHT - 1))
			bot_c = str_pkg::COORD_W'(str_pkg::FRAME_HEIGHT - 1);
		w_c = rgt_c - lft_c + str_pkg::COORD_W'(1);
		h_c = bot_c - tp_c + str_pkg::COORD_W'(1);
	end

	// drawn pixel position and distance from the rectangle centre row
	always_comb begin
		col_out = int'(drsp.quot) >= int'(w_q);
		fx_c    = str_pkg::COORD_W'(int'(left_q) + int'(drsp.quot[str_pkg::W_W-1:0]));
		fy_c    = str_pkg::COORD_W'(int'(top_q) + int'(row_q));
		addr_c  = str_pkg::addr_of(int'(fx_c), int'(fy_c));
		two_row = {row_q, 1'b0};
		row_dev = ({1'b0, c2_q} >= two_row) ? {1'b0, c2_q} - two_row : two_row - {1'b0, c2_q};
	end

	// divider requests: column first, then row gain
	always_comb begin
		dreq = '0;
		if (state_q == S_COL && w_q > 0 && hok_q && count_q != 16'd0) begin
			dreq.start = 1'b1;
			dreq.num   = str_pkg::DIV_NW'(int'(idx_q) * int'(w_q));
			dreq.den   = count_q;
		end else if (state_q == S_COL_WAIT && drsp.done && !col_out && c2_q != '0) begin
			dreq.start = 1'b1;
			dreq.num   = str_pkg::DIV_NW'(str_pkg::GAIN_NUM * int'(c2_q));
			dreq.den   = str_pkg::DIV_DW'(11 * int'(c2_q) - 10 * int'(row_dev));
		end
	end

	// saturating add of the shade onto the old pixel
	assign new_r = str_pkg::sat_add(ram_rdata[23:16], shade_q[23:16]);
	assign new_g = str_pkg::sat_add(ram_rdata[15:8], shade_q[15:8]);
	assign new_b = str_pkg::sat_add(ram_rdata[7:0], shade_q[7:0]);

	// frame store ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = str_pkg::addr_of(int'(req.pixel_x), int'(req.pixel_y));
		ram_wdata = req.pixel_data;
		ram_re    = 1'b0;
		ram_raddr = ram_waddr;
		if (state_q == S_IDLE) begin
			ram_we = accept && req.command == str_pkg::CMD_WRITE && in_frame;
			ram_re = accept && req.command == str_pkg::CMD_READ && in_frame;
		end else if (state_q == S_COL_WAIT) begin
			ram_re    = drsp.done && !col_out;
			ram_raddr = addr_c;
		end else if (state_q == S_SUM) begin
			ram_we    = 1'b1;
			ram_waddr = addr_q;
			ram_wdata = {new_r, new_g, new_b};
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_cfg_q   <= '0;
			top_cfg_q    <= '0;
			right_cfg_q  <= str_pkg::REG_W'(255);
			bottom_cfg_q <= str_pkg::REG_W'(255);
			red_q        <= 8'd0;
			green_q      <= 8'd255;
			blue_q       <= 8'd0;
			count_q      <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				str_pkg::REG_RECT_LEFT:   left_cfg_q   <= cfg_data[str_pkg::REG_W-1:0];
				str_pkg::REG_RECT_TOP:    top_cfg_q    <= cfg_data[str_pkg::REG_W-1:0];
				str_pkg::REG_RECT_RIGHT:  right_cfg_q  <= cfg_data[str_pkg::REG_W-1:0];
				str_pkg::REG_RECT_BOTTOM: bottom_cfg_q <= cfg_data[str_pkg::REG_W-1:0];
				str_pkg::REG_COLOR_RED:   red_q        <= cfg_data[7:0];
				str_pkg::REG_COLOR_GREEN: green_q      <= cfg_data[7:0];
				str_pkg::REG_COLOR_BLUE:  blue_q       <= cfg_data[7:0];
				str_pkg::REG_SAMPLE_CNT:  count_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer with registered response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sidx_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.command)
							str_pkg::CMD_READ:  state_q <= in_frame ? S_RD_WAIT : S_DONE;
							str_pkg::CMD_PLOT: begin
								sidx_q  <= (req.first_sample ? 16'd0 : sidx_q) + 16'd1;
								state_q <= S_PREP;
							end
							default:            state_q <= S_DONE;
						endcase
					end
				end
				S_PREP:      state_q <= S_COL;
				S_COL:       state_q <= dreq.start ? S_COL_WAIT : S_DONE;
				S_COL_WAIT: begin
					if (drsp.done) begin
						if (col_out)
							state_q <= S_DONE;
						else
							state_q <= (c2_q == '0) ? S_SHADE : S_GAIN_WAIT;
					end
				end
				S_GAIN_WAIT: if (drsp.done) state_q <= S_SHADE;
				S_SHADE:     state_q <= S_SUM;
				S_SUM:       state_q <= S_DONE;
				S_RD_WAIT:   state_q <= S_DONE;
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default:     state_q <= S_IDLE;
			endcase
		end
	end

	// plot datapath and response payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_q    <= '0;
				idx_q    <= req.first_sample ? 16'd0 : sidx_q;
				sample_q <= {~req.sample[15], req.sample[14:0]};
			end
			S_PREP: begin
				left_q <= lft_c;
				top_q  <= tp_c;
				w_q    <= w_c;
				hok_q  <= h_c > 0;
				c2_q   <= str_pkg::ROW_W'(h_c - str_pkg::COORD_W'(1));
			end
			S_COL: row_q <= str_pkg::ROW_W'((int'(c2_q) * int'(sample_q)) >>> 16);
			S_COL_WAIT: begin
				fx_q    <= fx_c;
				fy_q    <= fy_c;
				addr_q  <= addr_c;
				plain_q <= c2_q == '0;
			end
			S_GAIN_WAIT: gain_q <= drsp.quot[15:0];
			S_SHADE: begin
				shade_q <= {str_pkg::shade_ch(red_q, gain_q, plain_q),
				            str_pkg::shade_ch(green_q, gain_q, plain_q),
				            str_pkg::shade_ch(blue_q, gain_q, plain_q)};
			end
			S_SUM: begin
				res_q.plotted   <= 1'b1;
				res_q.plot_x    <= fx_q[7:0];
				res_q.plot_y    <= fy_q[7:0];
				res_q.new_pixel <= {new_r, new_g, new_b};
			end
			S_RD_WAIT: res_q.read_data <= ram_rdata;
			S_DONE: if (!rsp_valid_q || !rsp_stall) rsp_q <= res_q;
			default: ;
		endcase
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	str_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.dreq   (dreq),
		.drsp   (drsp)
	);

	str_fb_ram #(
		.ADDR_W (str_pkg::ADDR_W),
		.DATA_W (str_pkg::PIX_W)
	) u_fb_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== hdl/str_chk.sv =====
// Port-level checker of the scope trace renderer and its bind.
`include "scope_trace_render_top_macros.svh"

module str_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input str_pkg::rsp_t rsp
);

	// a stalled response holds
	`STR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// one request at a time: busy right after acceptance
	`STR_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

	// a drawn pixel never carries read data
	`STR_ASSERT_NOW(a_plot_no_read, rsp_valid && rsp.plotted, rsp.read_data == '0)

	// nothing drawn means the plot fields are zero
	`STR_ASSERT_NOW(a_noplot_zero, rsp_valid && !rsp.plotted, rsp.plot_x == '0 && rsp.plot_y == '0 && rsp.new_pixel == '0)

endmodule

bind scope_trace_render_top str_chk u_str_chk (.*);
